@@ rtl/assert_macros.svh @@
// assertion macros shared by the stopwatch rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, off while reset is low
`define BSW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsw assertion failed");

// implication checked in the next cycle, off while reset is low
`define BSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsw assertion failed");

`endif

@@ rtl/bsw_pkg.sv @@
// types, event codes and segment table for the bcd stopwatch
// no dependencies; used by every module of the block
package bsw_pkg;

    localparam int DIGITS_DEF = 4;

    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_BUTTON   = 3'd1;
    localparam logic [2:0] KIND_PAUSE_LK = 3'd2;
    localparam logic [2:0] KIND_RESET_LK = 3'd3;
    localparam logic [2:0] KIND_SCAN     = 3'd4;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef logic [3:0] t_digit;

    // one event as it leaves the input register
    typedef struct packed {
        logic       fire;
        logic [2:0] kind;
        logic       pause_pressed;
        logic       reset_pressed;
    } t_event;

    // what the scan drives after the event
    typedef struct packed {
        logic [7:0] segments;
        logic [1:0] digit_index;
        logic       blank;
    } t_scan;

    // active-high 0-F table; the active-low table (0xC0, 0xF9 ... 0x8E) is its inverse
    function automatic logic [7:0] seg_high(input t_digit d);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            4'hF: s = 8'h71;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/bsw_count.sv @@
// decimal counter, pause flag and button lockouts of the stopwatch
// depends on bsw_pkg and assert_macros.svh
`include "assert_macros.svh"

module bsw_count #(
    parameter int DIGITS = bsw_pkg::DIGITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bsw_pkg::t_event                      i_ev,
    output logic [DIGITS-1:0][3:0]               o_digits,   // state after the event
    output logic                                 o_paused
);

    logic [DIGITS-1:0][3:0] r_digits, n_digits;
    logic [DIGITS-1:0][3:0] inc_digits;
    logic [DIGITS:0]        carry;
    logic                   r_pause, n_pause;
    logic                   r_pause_lk, n_pause_lk;
    logic                   r_reset_lk, n_reset_lk;

    // ripple the decimal carry up through the digits
    always_comb begin
        carry[0] = 1'b1;
        for (int k = 0; k < DIGITS; k++) begin
            if (!carry[k]) begin
                inc_digits[k] = r_digits[k];
            end else if (r_digits[k] >= bsw_pkg::DIGIT_MAX) begin
                inc_digits[k] = '0;
            end else begin
                inc_digits[k] = r_digits[k] + 4'd1;
            end
            carry[k+1] = carry[k] && (r_digits[k] >= bsw_pkg::DIGIT_MAX);
        end
    end

    always_comb begin
        n_digits   = r_digits;
        n_pause    = r_pause;
        n_pause_lk = r_pause_lk;
        n_reset_lk = r_reset_lk;
        if (i_ev.fire) begin
            unique case (i_ev.kind)
                bsw_pkg::KIND_TICK: begin
                    if (!r_pause) n_digits = inc_digits;
                end
                bsw_pkg::KIND_BUTTON: begin
                    // pause press first, so a double press ends paused
                    if (i_ev.pause_pressed && !r_pause_lk) begin
                        n_pause    = !r_pause;
                        n_pause_lk = 1'b1;
                    end
                    if (i_ev.reset_pressed && !r_reset_lk) begin
                        n_pause    = 1'b1;
                        n_digits   = '0;
                        n_reset_lk = 1'b1;
                    end
                end
                bsw_pkg::KIND_PAUSE_LK: n_pause_lk = 1'b0;
                bsw_pkg::KIND_RESET_LK: n_reset_lk = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits   <= '0;
            r_pause    <= 1'b1;
            r_pause_lk <= 1'b0;
            r_reset_lk <= 1'b0;
        end else begin
            r_digits   <= n_digits;
            r_pause    <= n_pause;
            r_pause_lk <= n_pause_lk;
            r_reset_lk <= n_reset_lk;
        end
    end

    assign o_digits = n_digits;
    assign o_paused = n_pause;

    `BSW_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !i_ev.fire, $stable(r_digits) && $stable(r_pause) && $stable(r_pause_lk) && $stable(r_reset_lk))
    `BSW_ASSERT_IMPL(a_units_dec, i_clk, i_rst_n, 1'b1, r_digits[0] <= bsw_pkg::DIGIT_MAX)

endmodule

@@ rtl/bsw_scan.sv @@
// display multiplex phase and segment pattern selection
// depends on bsw_pkg and assert_macros.svh
`include "assert_macros.svh"

module bsw_scan #(
    parameter int DIGITS = bsw_pkg::DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bsw_pkg::t_event        i_ev,
    input  logic [DIGITS-1:0][3:0] i_digits,    // count after the event
    input  logic                   i_polarity,
    output bsw_pkg::t_scan         o_scan
);

    localparam int PHASE_W = $clog2(2 * DIGITS);
    localparam int SLOT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(2 * DIGITS - 1);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  pos;
    logic [SLOT_W:0]    pos_ext;
    logic               is_blank;

    always_comb begin
        n_phase = r_phase;
        if (i_ev.fire && i_ev.kind == bsw_pkg::KIND_SCAN) begin
            n_phase = (r_phase == PHASE_LAST) ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // units sit in the rightmost position
    assign slot     = SLOT_W'(n_phase >> 1);
    assign pos      = SLOT_W'(DIGITS - 1) - slot;
    assign pos_ext  = {1'b0, pos};
    assign is_blank = n_phase[0];

    always_comb begin
        if (is_blank) begin
            o_scan.segments = {8{i_polarity}};
        end else if (i_polarity) begin
            o_scan.segments = ~bsw_pkg::seg_high(i_digits[slot]);
        end else begin
            o_scan.segments = bsw_pkg::seg_high(i_digits[slot]);
        end
        o_scan.digit_index = pos_ext[1:0];
        o_scan.blank       = is_blank;
    end

    `BSW_ASSERT_IMPL(a_phase_range, i_clk, i_rst_n, 1'b1, r_phase <= PHASE_LAST)

endmodule

@@ rtl/bcd_stopwatch_seven_segment.sv @@
// top level of the four-digit bcd stopwatch with seven-segment scan
// depends on bsw_pkg, bsw_count, bsw_scan and assert_macros.svh
`include "assert_macros.svh"

// Each input transaction is one event (tick, button edge, lockout end or scan
// step) and yields exactly one output transaction showing the count, the pause
// flag and the display drive after that event. An input register feeds the
// counter and scan logic, whose results land in an output register. The block
// takes one event per clock, and a new event is accepted every cycle while
// the output side keeps taking. When the output is stalled the input register
// holds one more event before tready drops. display_polarity (reset 1,
// active-low segments) is written through i_cfg_wr_en and should only
// change while no event is in flight.
module bcd_stopwatch_seven_segment #(
    parameter int DIGITS = bsw_pkg::DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,   // display_polarity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [0] pause_pressed, [1] reset_pressed
    input  logic [2:0]  s_axis_tuser,    // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] units, [7:4] tens, [11:8] hundreds, [15:12] thousands,
    // [16] paused, [24:17] segments, [26:25] digit_index
    output logic [31:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser     // [0] blank
);

    logic                   r_polarity;
    logic                   r_in_valid;
    logic [2:0]             r_kind;
    logic                   r_pause_pressed;
    logic                   r_reset_pressed;
    logic                   r_out_valid;
    logic [31:0]            r_out_data;
    logic                   r_out_blank;
    logic                   fire;
    bsw_pkg::t_event        ev;
    bsw_pkg::t_scan         scan;
    logic [DIGITS-1:0][3:0] digits;
    logic                   paused;
    logic [3:0][3:0]        out_digits;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    assign ev.fire          = fire;
    assign ev.kind          = r_kind;
    assign ev.pause_pressed = r_pause_pressed;
    assign ev.reset_pressed = r_reset_pressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity  <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_polarity <= i_cfg_wr_data;
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_kind          <= s_axis_tuser;
            r_pause_pressed <= s_axis_tdata[0];
            r_reset_pressed <= s_axis_tdata[1];
        end
        if (fire) begin
            r_out_data  <= {5'd0, scan.digit_index, scan.segments, paused, out_digits};
            r_out_blank <= scan.blank;
        end
    end

    bsw_count #(
        .DIGITS (DIGITS)
    ) u_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ev     (ev),
        .o_digits (digits),
        .o_paused (paused)
    );

    bsw_scan #(
        .DIGITS (DIGITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev       (ev),
        .i_digits   (digits),
        .i_polarity (r_polarity),
        .o_scan     (scan)
    );

    // digit fields past the configured width read zero
    for (genvar k = 0; k < 4; k++) begin : g_out_digit
        if (k < DIGITS) begin : g_used
            assign out_digits[k] = digits[k];
        end else begin : g_unused
            assign out_digits[k] = '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_blank;

    `BSW_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, r_in_valid && !s_axis_tready, r_out_valid && !m_axis_tready)
    `BSW_ASSERT_NEXT(a_fire_out, i_clk, i_rst_n, fire, r_out_valid)

endmodule
